// File: src/lzwr_pkg.sv
`default_nettype none

package lzwr_pkg;

  // History window and group geometry.
  localparam int WIN_DEPTH     = 4096;
  localparam int WIN_AW        = $clog2(WIN_DEPTH);
  localparam int TOK_PER_GROUP = 16;
  localparam int TOK_IDX_W     = $clog2(TOK_PER_GROUP);
  localparam int GRP_W         = 5;

  // Field widths.
  localparam int SIZE_W = 24;
  localparam int RUN_W  = 13;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;

  // A clear-bit token whose top nibble is this code is a repeat run.
  localparam logic [3:0] REP_CODE = 4'h0;

  // Fixed length bias of repeat runs and copies.
  localparam int REP_BIAS  = 3;
  localparam int COPY_BIAS = 2;

  // Reset values of the registers.
  localparam logic [SIZE_W-1:0] OUT_SIZE_RST = 24'd1;
  localparam logic [BYTE_W-1:0] FILL_RST     = 8'hEE;

  // Configuration register indexes.
  localparam logic CFG_OUT_SIZE = 1'b0;
  localparam logic CFG_FILL     = 1'b1;

  // Access to the history memory for one cycle.
  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
  } hist_req_t;

endpackage

`default_nettype wire

// File: src/lzwr_hist.sv
`default_nettype none

module lzwr_hist (
  input  wire logic                     clk,
  input  wire lzwr_pkg::hist_req_t      req,
  output logic [lzwr_pkg::BYTE_W-1:0]   rdata
);
  import lzwr_pkg::*;

  logic [BYTE_W-1:0] mem [WIN_DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/lz_window_rle_decompressor.sv
// Sliding-window LZ decompressor with run-length repeats.
// Input channel s_*: one 16-bit word per item; s_tuser high marks a flag word that
// opens a group, with the group size in s_tdata[20:16]. Output channel m_*: one
// decompressed byte (or one repeat run with its count) per item; m_tlast marks the
// final item caused by an input word and m_tuser marks that the output size is reached.
// Configuration channel cfg_*: index 0 sets out_size, index 1 sets fill_byte; it is
// always ready, and the user must write it only while the block is idle; the block
// itself does not enforce this. A flag word or an ignored token is consumed in the idle
// state; a literal passes through the decode state and then its high and low byte
// states; a repeat run writes every repeated byte into the 4096-byte history through
// its single write port; a copy needs a registered history read for each byte before
// it is written back and sent. A literal's first result is loaded from its high-byte
// state, a copy's from its first write state and a repeat run's with its last byte.
// s_tready is high only while the sequencer is idle. A stalled receiver holds the
// output register, and the sequencer waits on it; one new item is still accepted
// while a finished result waits in the output register.
// Synchronous reset clears the counters and the group state and restores
// out_size = 1 and fill_byte = 0xEE. The history is not cleared: reads that would
// reach before the first written byte return fill_byte instead.

`default_nettype none

module lz_window_rle_decompressor (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // word[15:0], group_tokens[20:16], zero[23:21]
  input  wire logic        s_tuser,   // is_flags
  // Result items.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_byte[7:0], run_count[20:8], zero[23:21]
  output logic             m_tlast,
  output logic             m_tuser,   // done_res
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);
  import lzwr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_LIT_HI = 3'd2;
  localparam logic [2:0] S_LIT_LO = 3'd3;
  localparam logic [2:0] S_REP    = 3'd4;
  localparam logic [2:0] S_CP_RD  = 3'd5;
  localparam logic [2:0] S_CP_WR  = 3'd6;

  logic [2:0]           state;
  logic [SIZE_W-1:0]    out_size;
  logic [BYTE_W-1:0]    fill_byte;
  logic [SIZE_W-1:0]    bytes_written;
  logic [WORD_W-1:0]    group_flags;
  logic [GRP_W-1:0]     token_index;
  logic [GRP_W-1:0]     group_size;
  logic [BYTE_W-1:0]    prev_byte;
  logic [WORD_W-1:0]    word;
  logic                 is_lit;
  logic [SIZE_W-1:0]    remaining;
  logic [RUN_W-1:0]     count;
  logic [RUN_W-1:0]     run_len;
  logic [BYTE_W-1:0]    rep_byte;
  logic [WIN_AW-1:0]    offset;
  logic                 src_fill;

  logic [BYTE_W-1:0]    out_byte;
  logic [RUN_W-1:0]     run_count;

  // Input field views.
  logic [WORD_W-1:0]    in_word;
  logic [GRP_W-1:0]     in_group_tokens;
  assign in_word         = s_tdata[WORD_W-1:0];
  assign in_group_tokens = s_tdata[WORD_W+GRP_W-1:WORD_W];

  // Sequencer outputs for this cycle.
  logic                 can_load;
  logic                 emit;
  logic [BYTE_W-1:0]    e_byte;
  logic [RUN_W-1:0]     e_run;
  logic                 e_last;
  logic                 e_done;
  logic                 step;
  logic [BYTE_W-1:0]    wbyte;
  logic                 rd_en;
  hist_req_t            hist_req;
  logic [BYTE_W-1:0]    hist_q;

  // Length candidates for the token being decoded.
  logic [RUN_W-1:0]     rep_len;
  logic [RUN_W-1:0]     copy_len;
  logic [SIZE_W-1:0]    src_reach;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign can_load  = !m_tvalid || m_tready;

  assign rep_len   = {1'b0, word[WIN_AW-1:0]} + RUN_W'(REP_BIAS);
  assign copy_len  = RUN_W'(word[WORD_W-1:WIN_AW]) + RUN_W'(COPY_BIAS);
  assign src_reach = SIZE_W'(offset);

  // Per-state emission and history write.
  always_comb begin
    emit   = 1'b0;
    e_byte = '0;
    e_run  = RUN_W'(1);
    e_last = 1'b0;
    e_done = (remaining == SIZE_W'(1));
    step   = 1'b0;
    wbyte  = '0;
    rd_en  = 1'b0;
    unique case (state)
      S_LIT_HI: begin
        emit   = can_load;
        step   = can_load;
        e_byte = word[WORD_W-1:BYTE_W];
        wbyte  = word[WORD_W-1:BYTE_W];
        e_last = (remaining == SIZE_W'(1));
      end
      S_LIT_LO: begin
        emit   = can_load;
        step   = can_load;
        e_byte = word[BYTE_W-1:0];
        wbyte  = word[BYTE_W-1:0];
        e_last = 1'b1;
      end
      S_REP: begin
        wbyte  = rep_byte;
        e_byte = rep_byte;
        e_run  = run_len;
        e_last = 1'b1;
        if (count == RUN_W'(1)) begin
          emit = can_load;
          step = can_load;
        end else begin
          step = 1'b1;
        end
      end
      S_CP_RD: begin
        rd_en = 1'b1;
      end
      S_CP_WR: begin
        emit   = can_load;
        step   = can_load;
        e_byte = src_fill ? fill_byte : hist_q;
        wbyte  = src_fill ? fill_byte : hist_q;
        e_last = (count == RUN_W'(1));
      end
      default: begin
      end
    endcase
  end

  // History memory access.
  always_comb begin
    hist_req.we    = step;
    hist_req.waddr = bytes_written[WIN_AW-1:0];
    hist_req.wdata = wbyte;
    hist_req.re    = rd_en;
    hist_req.raddr = bytes_written[WIN_AW-1:0] - offset;
  end

  lzwr_hist u_hist (
    .clk   (clk),
    .req   (hist_req),
    .rdata (hist_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_size  <= OUT_SIZE_RST;
      fill_byte <= FILL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OUT_SIZE: out_size  <= cfg_data;
        CFG_FILL:     fill_byte <= cfg_data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bytes_written <= '0;
      group_flags   <= '0;
      token_index   <= '0;
      group_size    <= '0;
      prev_byte     <= FILL_RST;
    end else begin
      // Each written byte advances the output position.
      if (step) begin
        bytes_written <= bytes_written + SIZE_W'(1);
        remaining     <= remaining - SIZE_W'(1);
        prev_byte     <= wbyte;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              group_flags <= in_word;
              group_size  <= (in_group_tokens > GRP_W'(TOK_PER_GROUP)) ?
                             GRP_W'(TOK_PER_GROUP) : in_group_tokens;
              token_index <= '0;
            end else if (token_index < group_size) begin
              token_index <= token_index + GRP_W'(1);
              if (bytes_written < out_size) begin
                word      <= in_word;
                is_lit    <= group_flags[token_index[TOK_IDX_W-1:0]];
                remaining <= out_size - bytes_written;
                state     <= S_DEC;
              end
            end
          end
        end
        S_DEC: begin
          if (is_lit) begin
            state <= S_LIT_HI;
          end else if (word[WORD_W-1:WIN_AW] == REP_CODE) begin
            // Repeat run: clamp the length and pick the byte.
            if (SIZE_W'(rep_len) > remaining) begin
              count   <= remaining[RUN_W-1:0];
              run_len <= remaining[RUN_W-1:0];
            end else begin
              count   <= rep_len;
              run_len <= rep_len;
            end
            rep_byte <= (bytes_written == '0) ? fill_byte : prev_byte;
            state    <= S_REP;
          end else begin
            // Window copy.
            if (SIZE_W'(copy_len) > remaining) begin
              count <= remaining[RUN_W-1:0];
            end else begin
              count <= copy_len;
            end
            offset <= word[WIN_AW-1:0];
            state  <= S_CP_RD;
          end
        end
        S_LIT_HI: begin
          if (can_load) begin
            state <= (remaining == SIZE_W'(1)) ? S_IDLE : S_LIT_LO;
          end
        end
        S_LIT_LO: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        S_REP: begin
          if (step) begin
            count <= count - RUN_W'(1);
            if (count == RUN_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_CP_RD: begin
          // Source before the first byte, or offset zero, reads the fill byte.
          src_fill <= (offset == '0) || (src_reach > bytes_written);
          state    <= S_CP_WR;
        end
        S_CP_WR: begin
          if (can_load) begin
            count <= count - RUN_W'(1);
            state <= (count == RUN_W'(1)) ? S_IDLE : S_CP_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= e_byte;
      run_count <= e_run;
      m_tlast   <= e_last;
      m_tuser   <= e_done;
    end
  end

  assign m_tdata = {3'b000, run_count, out_byte};

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
  import lzwr_pkg::*;

  // One input word with its flag marker and group size.
  typedef struct {
    logic [WORD_W-1:0] word;
    logic              flg;
    logic [GRP_W-1:0]  gt;
  } word_item_t;

  // One expected output byte or repeat run.
  typedef struct {
    logic [BYTE_W-1:0] val;
    logic [RUN_W-1:0]  run;
    logic              last;
    logic              done;
  } byte_run_t;

  localparam int TAIL_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // word[15:0], group_tokens[20:16], zero[23:21]
  logic        s_tuser = 1'b0; // is_flags
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // out_byte[7:0], run_count[20:8], zero[23:21]
  logic        m_tlast;
  logic        m_tuser;        // done_res
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_OUT_SIZE;
  logic [23:0] cfg_data = '0;

  // Stimulus and scoreboard bookkeeping.
  word_item_t  pending_words[$];
  byte_run_t   bytes_due[$];
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        pressure_arm = 1'b0;
  logic        pressure_used = 1'b0;
  int unsigned hold_left = 0;

  // Decoder state mirrored by the predictor.
  logic [BYTE_W-1:0] win_mem [WIN_DEPTH];
  logic [SIZE_W-1:0] wr_count = '0;
  logic [WORD_W-1:0] grp_flags = '0;
  logic [GRP_W-1:0]  tok_idx = '0;
  logic [GRP_W-1:0]  grp_size = '0;
  logic [BYTE_W-1:0] last_byte = FILL_RST;
  logic [SIZE_W-1:0] size_lim = OUT_SIZE_RST;
  logic [BYTE_W-1:0] fill_val = FILL_RST;

  lz_window_rle_decompressor u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) begin
      $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
    end
  endtask

  // Write reps copies of one byte into the history and expect one result item.
  task automatic emit_byte(input logic [BYTE_W-1:0] b, input int unsigned reps);
    int unsigned k;
    byte_run_t r;
    for (k = 0; k < reps; k++) begin
      win_mem[wr_count[WIN_AW-1:0]] = b;
      wr_count = wr_count + 1'b1;
    end
    last_byte = b;
    r.val = b;
    r.run = reps[RUN_W-1:0];
    r.last = 1'b0;
    r.done = (wr_count >= size_lim);
    bytes_due.push_back(r);
  endtask

  // Decode one accepted word and queue the bytes it should produce.
  task automatic decode_word(input word_item_t it);
    logic              flag_bit;
    logic [SIZE_W-1:0] room;
    logic [11:0]       ofs;
    logic [WIN_AW-1:0] rd_at;
    logic [BYTE_W-1:0] b;
    int unsigned       len;
    int unsigned       k;
    int unsigned       n0;
    byte_run_t         r;
    n0 = bytes_due.size();
    if (it.flg) begin
      grp_flags = it.word;
      grp_size = (it.gt > TOK_PER_GROUP) ? GRP_W'(TOK_PER_GROUP) : it.gt;
      tok_idx = '0;
    end else if (tok_idx < grp_size) begin
      flag_bit = grp_flags[tok_idx[3:0]];
      tok_idx = tok_idx + 1'b1;
      if (wr_count < size_lim) begin
        room = size_lim - wr_count;
        if (flag_bit) begin
          // Literal: high byte first, low byte only if there is room.
          emit_byte(it.word[15:8], 1);
          if (room > 1) emit_byte(it.word[7:0], 1);
        end else if (it.word[15:12] == REP_CODE) begin
          // Repeat run of the previous byte, fill byte before any output.
          b = (wr_count == 0) ? fill_val : last_byte;
          len = it.word + REP_BIAS;
          if (len > room) len = room;
          emit_byte(b, len);
        end else begin
          // Copy from the history window one byte at a time.
          ofs = it.word[11:0];
          len = it.word[15:12] + COPY_BIAS;
          if (len > room) len = room;
          for (k = 0; k < len; k++) begin
            if (ofs == 0 || ofs > wr_count) begin
              b = fill_val;
            end else begin
              rd_at = wr_count[WIN_AW-1:0] - ofs;
              b = win_mem[rd_at];
            end
            emit_byte(b, 1);
          end
        end
      end
    end
    if (bytes_due.size() > n0) begin
      r = bytes_due.pop_back();
      r.last = 1'b1;
      bytes_due.push_back(r);
    end
  endtask

  // Sample handshakes, update the predictor and check result items.
  always @(posedge clk) begin
    word_item_t it;
    byte_run_t  exp_r;
    if (rst) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OUT_SIZE) size_lim = cfg_data;
        else fill_val = cfg_data[BYTE_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        it.word = s_tdata[15:0];
        it.gt = s_tdata[20:16];
        it.flg = s_tuser;
        decode_word(it);
        words_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (bytes_due.size() == 0) begin
          report_mismatch("unexpected item", m_tdata, 0);
        end else begin
          exp_r = bytes_due.pop_front();
          if (m_tdata[7:0] != exp_r.val) report_mismatch("out_byte", m_tdata[7:0], exp_r.val);
          if (m_tdata[20:8] != exp_r.run)
            report_mismatch("run_count", m_tdata[20:8], exp_r.run);
          if (m_tlast != exp_r.last) report_mismatch("last", m_tlast, exp_r.last);
          if (m_tuser != exp_r.done) report_mismatch("done", m_tuser, exp_r.done);
        end
      end
    end
  end

  // Input driver: offers the next pending word unless the current one is still waiting.
  always @(negedge clk) begin
    word_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        it = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, it.gt, it.word};
        s_tuser <= it.flg;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down once when armed.
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
      pressure_used <= 1'b0;
    end else if (pressure_arm && !pressure_used) begin
      hold_left <= HOLD_CYCLES;
      pressure_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stalls plus the hold-off.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  task automatic queue_word(input logic [WORD_W-1:0] w, input logic flg,
                            input logic [GRP_W-1:0] gt);
    word_item_t it;
    it.word = w;
    it.flg = flg;
    it.gt = gt;
    pending_words.push_back(it);
    words_queued++;
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every word is taken and every result has arrived, then let the block settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || words_taken != words_queued || bytes_due.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // A clear-bit token: mostly short repeats and near copies.
  function automatic logic [WORD_W-1:0] pick_clear_token();
    logic [WORD_W-1:0] w;
    logic [11:0]       code;
    int unsigned       sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      if ($urandom_range(99) < 3) code = 12'($urandom_range(4095));
      else code = 12'($urandom_range(12));
      w = {REP_CODE, code};
    end else begin
      sel = $urandom_range(99);
      if (sel < 70) code = 12'($urandom_range(48, 1));
      else if (sel < 80) code = '0;
      else code = 12'($urandom_range(4095));
      w = {4'($urandom_range(15, 1)), code};
    end
    return w;
  endfunction

  // One group: a flag word and its tokens, sometimes cut short or overrun.
  task automatic queue_group(output int unsigned used);
    logic [WORD_W-1:0] flags;
    logic [GRP_W-1:0]  gt;
    int unsigned       ntok;
    int unsigned       nreal;
    int unsigned       k;
    int unsigned       r;
    flags = WORD_W'($urandom);
    r = $urandom_range(99);
    if (r < 88) gt = GRP_W'($urandom_range(16, 1));
    else if (r < 92) gt = '0;
    else gt = GRP_W'($urandom_range(31, 17));
    queue_word(flags, 1'b1, gt);
    nreal = (gt > TOK_PER_GROUP) ? TOK_PER_GROUP : gt;
    ntok = nreal;
    r = $urandom_range(99);
    if (r < 8 && ntok > 0) ntok = $urandom_range(ntok - 1);
    else if (r < 16) ntok = ntok + $urandom_range(3, 1);
    for (k = 0; k < ntok; k++) begin
      if (flags[k % 16]) queue_word(WORD_W'($urandom_range(65535)), 1'b0,
                                    GRP_W'($urandom_range(31)));
      else queue_word(pick_clear_token(), 1'b0, GRP_W'($urandom_range(31)));
    end
    used = 1 + ((ntok < nreal) ? ntok : nreal);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned n, input logic hold);
    int unsigned cnt;
    int unsigned used;
    cnt = 0;
    @(posedge clk);
    idle_pct = idle;
    stall_pct = stall;
    while (cnt < n) begin
      queue_group(used);
      cnt += used;
    end
    if (hold) pressure_arm = 1'b1;
    wait_drained();
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Tokens outside any group, an empty group, repeat before any output, output full.
    @(posedge clk);
    queue_word(16'h1234, 1'b0, 5'd0);
    queue_word(16'h0002, 1'b1, 5'd0);
    queue_word(16'h0001, 1'b0, 5'd0);
    queue_word(16'h0002, 1'b1, 5'd2);
    queue_word(16'h0005, 1'b0, 5'd0);
    queue_word(16'hABCD, 1'b0, 5'd0);
    queue_word(16'hF00F, 1'b0, 5'd31);
    wait_drained();

    // A literal with a single byte of room left.
    write_reg(CFG_OUT_SIZE, 24'd2);
    @(posedge clk);
    queue_word(16'h0001, 1'b1, 5'd1);
    queue_word(16'hABCD, 1'b0, 5'd0);
    wait_drained();

    // Oversized group, extreme literals, zero offset, reach before start, short repeat.
    write_reg(CFG_OUT_SIZE, 24'hFFFFFF);
    write_reg(CFG_FILL, 24'h000000);
    @(posedge clk);
    queue_word(16'h0005, 1'b1, 5'd31);
    queue_word(16'hFFFF, 1'b0, 5'd0);
    queue_word(16'hF000, 1'b0, 5'd0);
    queue_word(16'h0000, 1'b0, 5'd0);
    queue_word(16'h0000, 1'b0, 5'd0);
    queue_word(16'h1FFF, 1'b0, 5'd0);
    queue_word(16'h3002, 1'b0, 5'd0);
    wait_drained();

    // Copy length clamped by the output size, then a token once full.
    write_reg(CFG_FILL, 24'h0000FF);
    write_reg(CFG_OUT_SIZE, wr_count + 24'd5);
    @(posedge clk);
    queue_word(16'h0000, 1'b1, 5'd3);
    queue_word(16'hF001, 1'b0, 5'd0);
    queue_word(16'h0000, 1'b0, 5'd0);
    wait_drained();

    // Output size lowered below the bytes already written.
    write_reg(CFG_OUT_SIZE, 24'd1);
    @(posedge clk);
    queue_word(16'hFFFF, 1'b1, 5'd16);
    queue_word(16'h5A5A, 1'b0, 5'd0);
    wait_drained();

    // Random groups under the different flow-control patterns.
    write_reg(CFG_OUT_SIZE, 24'hFFFFFF);
    write_reg(CFG_FILL, 24'($urandom_range(255)));
    run_phase(0, 0, 32, 1'b1);
    write_reg(CFG_OUT_SIZE, wr_count + 24'd150);
    write_reg(CFG_FILL, 24'($urandom_range(255)));
    run_phase(74, 0, 32, 1'b0);
    write_reg(CFG_OUT_SIZE, 24'hFFFFFF);
    write_reg(CFG_FILL, 24'($urandom_range(255)));
    run_phase(0, 74, 32, 1'b0);
    write_reg(CFG_FILL, 24'($urandom_range(255)));
    run_phase(15, 15, 32, 1'b0);

    if (mismatch_cnt == 0 && bytes_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
